// File: rtl/differential_drive_pd_move_top_assert.svh
// Assertion macros shared by the checker files of this block.
// Both take a label, a clock, a reset, an antecedent, a consequent and a message.
`ifndef DIFFERENTIAL_DRIVE_PD_MOVE_TOP_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_PD_MOVE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDPM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DDPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ddpm_pkg.sv
`timescale 1ns / 1ps

package ddpm_pkg;

  localparam logic signed [36:0] DRIVE_LIMIT = 37'sd25600;
  localparam logic signed [15:0] DRIVE_LIMIT_16 = 16'sd25600;

  localparam logic [30:0] TOL_RESET       = 31'd3277;
  localparam logic [15:0] MAIN_GP_RESET   = 16'd512;
  localparam logic [15:0] MAIN_GD_RESET   = 16'd0;
  localparam logic [15:0] STEER_GP_RESET  = 16'd128;
  localparam logic [15:0] STEER_GD_RESET  = 16'd0;

  // Register map, word index into the configuration space.
  typedef enum logic [2:0] {
    REG_MOVE_MODE      = 3'd0,
    REG_MOVE_TARGET    = 3'd1,
    REG_STOP_TOLERANCE = 3'd2,
    REG_MAIN_GAIN_P    = 3'd3,
    REG_MAIN_GAIN_D    = 3'd4,
    REG_STEER_GAIN_P   = 3'd5,
    REG_STEER_GAIN_D   = 3'd6
  } reg_addr_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef enum logic {
    MODE_STRAIGHT = 1'b0,
    MODE_ROTATE   = 1'b1
  } move_mode_t;

  // Saturate a 34-bit signed value into the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Clamp to the drive range of +-100 percent in Q8.8.
  function automatic logic signed [36:0] clamp_drive(input logic signed [36:0] v);
    logic signed [36:0] r;
    if (v > DRIVE_LIMIT) begin
      r = DRIVE_LIMIT;
    end else if (v < -DRIVE_LIMIT) begin
      r = -DRIVE_LIMIT;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // True when the magnitude of the error is at or below the tolerance.
  function automatic logic within_tol(input logic signed [31:0] err,
                                      input logic [30:0] tol);
    logic signed [32:0] ext;
    logic [32:0] mag;
    ext = {err[31], err};
    mag = err[31] ? 33'(-ext) : 33'(ext);
    return mag <= {2'b00, tol};
  endfunction

endpackage

// File: rtl/ddpm_pd_term.sv
`timescale 1ns / 1ps

module ddpm_pd_term (
  input  logic [15:0]        gain_p,
  input  logic [15:0]        gain_d,
  input  logic signed [31:0] err,
  input  logic signed [31:0] prev,
  output logic signed [34:0] term
);

  logic signed [32:0] diff;
  logic signed [48:0] prod_p;
  logic signed [49:0] prod_d;
  logic signed [50:0] sum;
  logic signed [50:0] biased;

  assign diff   = $signed({err[31], err}) - $signed({prev[31], prev});
  assign prod_p = $signed({1'b0, gain_p}) * err;
  assign prod_d = $signed({1'b0, gain_d}) * diff;
  assign sum    = $signed({{2{prod_p[48]}}, prod_p}) + $signed({prod_d[49], prod_d});

  // Division by 65536 rounds toward zero, so negative sums get a bias first.
  assign biased = sum + $signed({35'd0, {16{sum[50]}}});
  assign term   = biased[50:16];

endmodule

// File: rtl/differential_drive_pd_move_top.sv
// Two-wheel PD move controller. A start beat (tuser 0) loads the remaining
// error from move_target; tick beats (tuser 1) carry wheel distance and angle
// deltas and yield left and right drives in Q8.8 percent, clamped to +-100,
// with move_done raised and the drives braked once the error is within
// stop_tolerance or while no move is active. Every input beat gives exactly
// one result beat. The block takes one beat per clock unless the result
// stream stalls; the error update, both PD multiplies and the drive mix sit
// between its input register and its result register. The error state is
// written along with the result register, so consecutive ticks need no gap.
// The user must write configuration through the APB port only while no beat
// is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps

module differential_drive_pd_move_top (
  input  logic         clk,
  input  logic         rst,
  // Input stream. tdata: left_dist_delta, right_dist_delta, left_angle_delta,
  // right_angle_delta (32 bits each, from bit 0 up). tuser: cmd.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic [0:0]   s_tuser,
  // Result stream. tdata: left_drive [15:0], right_drive [31:16],
  // move_done [32], remaining_error [64:33], zero fill [71:65].
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // Configuration registers.
  logic               move_mode;
  logic signed [31:0] move_target;
  logic [30:0]        stop_tolerance;
  logic [15:0]        main_gain_p;
  logic [15:0]        main_gain_d;
  logic [15:0]        steer_gain_p;
  logic [15:0]        steer_gain_d;

  // Controller state.
  logic               move_active;
  logic signed [31:0] main_error;
  logic signed [31:0] steer_error;
  logic               move_active_next;
  logic signed [31:0] main_error_next;
  logic signed [31:0] steer_error_next;

  // Input register.
  logic               s1_valid;
  logic               s1_cmd;
  logic signed [31:0] s1_ld;
  logic signed [31:0] s1_rd;
  logic signed [31:0] s1_la;
  logic signed [31:0] s1_ra;

  // Result register.
  logic               out_done;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic signed [31:0] out_err;
  logic               out_done_next;
  logic signed [15:0] out_left_next;
  logic signed [15:0] out_right_next;

  logic s2_adv;
  logic s1_fire;
  logic cfg_wr;
  ddpm_pkg::reg_addr_t cfg_addr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign cfg_addr = ddpm_pkg::reg_addr_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      move_mode      <= ddpm_pkg::MODE_STRAIGHT;
      move_target    <= '0;
      stop_tolerance <= ddpm_pkg::TOL_RESET;
      main_gain_p    <= ddpm_pkg::MAIN_GP_RESET;
      main_gain_d    <= ddpm_pkg::MAIN_GD_RESET;
      steer_gain_p   <= ddpm_pkg::STEER_GP_RESET;
      steer_gain_d   <= ddpm_pkg::STEER_GD_RESET;
    end else if (cfg_wr) begin
      case (cfg_addr)
        ddpm_pkg::REG_MOVE_MODE:      move_mode      <= pwdata[0];
        ddpm_pkg::REG_MOVE_TARGET:    move_target    <= pwdata;
        ddpm_pkg::REG_STOP_TOLERANCE: stop_tolerance <= pwdata[30:0];
        ddpm_pkg::REG_MAIN_GAIN_P:    main_gain_p    <= pwdata[15:0];
        ddpm_pkg::REG_MAIN_GAIN_D:    main_gain_d    <= pwdata[15:0];
        ddpm_pkg::REG_STEER_GAIN_P:   steer_gain_p   <= pwdata[15:0];
        ddpm_pkg::REG_STEER_GAIN_D:   steer_gain_d   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_addr)
      ddpm_pkg::REG_MOVE_MODE:      prdata = {31'd0, move_mode};
      ddpm_pkg::REG_MOVE_TARGET:    prdata = move_target;
      ddpm_pkg::REG_STOP_TOLERANCE: prdata = {1'b0, stop_tolerance};
      ddpm_pkg::REG_MAIN_GAIN_P:    prdata = {16'd0, main_gain_p};
      ddpm_pkg::REG_MAIN_GAIN_D:    prdata = {16'd0, main_gain_d};
      ddpm_pkg::REG_STEER_GAIN_P:   prdata = {16'd0, steer_gain_p};
      ddpm_pkg::REG_STEER_GAIN_D:   prdata = {16'd0, steer_gain_d};
      default:                      prdata = '0;
    endcase
  end

  // Two-stage pipeline: the input register advances whenever the result
  // register is empty or is being drained.
  assign s2_adv   = ~m_tvalid | m_tready;
  assign s1_fire  = s1_valid & s2_adv;
  assign s_tready = ~s1_valid | s2_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready & s_tvalid) begin
      s1_cmd <= s_tuser[0];
      s1_ld  <= s_tdata[31:0];
      s1_rd  <= s_tdata[63:32];
      s1_la  <= s_tdata[95:64];
      s1_ra  <= s_tdata[127:96];
    end
  end

  // Error update for a tick.
  logic signed [32:0] sum_dist;
  logic signed [32:0] sum_angle;
  logic signed [32:0] sum_sel;
  logic signed [32:0] half;
  logic signed [33:0] main_raw;
  logic signed [32:0] steer_raw;
  logic signed [31:0] main_new;
  logic signed [31:0] steer_new;
  logic               tick_done;
  logic               start_done;

  assign sum_dist  = $signed({s1_ld[31], s1_ld}) + $signed({s1_rd[31], s1_rd});
  assign sum_angle = $signed({s1_la[31], s1_la}) + $signed({s1_ra[31], s1_ra});
  assign sum_sel   = (move_mode == ddpm_pkg::MODE_ROTATE) ? sum_angle : sum_dist;
  // Halving rounds toward zero: a negative odd sum is nudged up by one.
  assign half      = (sum_sel + $signed({32'd0, sum_sel[32] & sum_sel[0]})) >>> 1;
  assign main_raw  = $signed({{2{main_error[31]}}, main_error}) - $signed({half[32], half});
  assign steer_raw = (move_mode == ddpm_pkg::MODE_ROTATE) ?
                     ($signed({s1_rd[31], s1_rd}) + $signed({s1_ld[31], s1_ld})) :
                     ($signed({s1_rd[31], s1_rd}) - $signed({s1_ld[31], s1_ld}));
  assign main_new  = ddpm_pkg::sat32(main_raw);
  assign steer_new = ddpm_pkg::sat32($signed({steer_raw[32], steer_raw}));

  assign tick_done  = ddpm_pkg::within_tol(main_new, stop_tolerance);
  assign start_done = ddpm_pkg::within_tol(move_target, stop_tolerance);

  logic signed [34:0] main_term;
  logic signed [34:0] steer_term;

  ddpm_pd_term u_main_pd (
    .gain_p (main_gain_p),
    .gain_d (main_gain_d),
    .err    (main_new),
    .prev   (main_error),
    .term   (main_term)
  );

  ddpm_pd_term u_steer_pd (
    .gain_p (steer_gain_p),
    .gain_d (steer_gain_d),
    .err    (steer_new),
    .prev   (steer_error),
    .term   (steer_term)
  );

  // Drive mix.
  logic signed [36:0] mt_x;
  logic signed [36:0] st_x;
  logic signed [36:0] mt_clamped;
  logic signed [36:0] left_raw;
  logic signed [36:0] right_raw;
  logic signed [36:0] left_sat;
  logic signed [36:0] right_sat;

  assign mt_x       = $signed({{2{main_term[34]}}, main_term});
  assign st_x       = $signed({{2{steer_term[34]}}, steer_term});
  assign mt_clamped = ddpm_pkg::clamp_drive(mt_x);

  always_comb begin
    if (move_mode == ddpm_pkg::MODE_ROTATE) begin
      left_raw  = mt_x - st_x;
      right_raw = -mt_x - st_x;
    end else begin
      left_raw  = mt_clamped + st_x;
      right_raw = mt_clamped - st_x;
    end
  end

  assign left_sat  = ddpm_pkg::clamp_drive(left_raw);
  assign right_sat = ddpm_pkg::clamp_drive(right_raw);

  always_comb begin
    move_active_next = move_active;
    main_error_next  = main_error;
    steer_error_next = steer_error;
    out_done_next    = 1'b1;
    out_left_next    = '0;
    out_right_next   = '0;
    if (s1_cmd == ddpm_pkg::CMD_START) begin
      main_error_next  = move_target;
      steer_error_next = '0;
      move_active_next = ~start_done;
      out_done_next    = start_done;
    end else if (move_active) begin
      main_error_next  = main_new;
      steer_error_next = steer_new;
      if (tick_done) begin
        move_active_next = 1'b0;
      end else begin
        out_done_next  = 1'b0;
        out_left_next  = left_sat[15:0];
        out_right_next = right_sat[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      move_active <= 1'b0;
      main_error  <= '0;
      steer_error <= '0;
    end else if (s1_fire) begin
      move_active <= move_active_next;
      main_error  <= main_error_next;
      steer_error <= steer_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_done  <= out_done_next;
      out_left  <= out_left_next;
      out_right <= out_right_next;
      out_err   <= main_error_next;
    end
  end

  assign m_tdata = {7'd0, out_err, out_done, out_right, out_left};

endmodule

// File: rtl/ddpm_checker.sv
`timescale 1ns / 1ps
`include "differential_drive_pd_move_top_assert.svh"

module ddpm_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [71:0]  m_tdata
);

  logic out_stall;
  logic done_beat;
  logic drive_ok;

  assign out_stall = m_tvalid & ~m_tready;
  assign done_beat = m_tvalid & m_tdata[32];
  assign drive_ok  = ($signed(m_tdata[15:0]) <= ddpm_pkg::DRIVE_LIMIT_16) &&
                     ($signed(m_tdata[15:0]) >= -ddpm_pkg::DRIVE_LIMIT_16) &&
                     ($signed(m_tdata[31:16]) <= ddpm_pkg::DRIVE_LIMIT_16) &&
                     ($signed(m_tdata[31:16]) >= -ddpm_pkg::DRIVE_LIMIT_16);

  // A held result beat must not change under backpressure.
  `DDPM_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_tvalid && $stable(m_tdata), "held beat changed")

  // Input is refused only while a finished result waits to be taken.
  `DDPM_ASSERT_SAME(a_stall_cause, clk, rst, !s_tready, out_stall, "input stalled without backpressure")

  // A finished or idle move always brakes both wheels.
  `DDPM_ASSERT_SAME(a_done_brakes, clk, rst, done_beat, m_tdata[31:0] == 32'd0, "done beat not braked")

  // Both drives stay inside +-100 percent.
  `DDPM_ASSERT_SAME(a_drive_range, clk, rst, m_tvalid, drive_ok, "drive out of range")

endmodule

bind differential_drive_pd_move_top ddpm_checker u_ddpm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/sv/differential_drive_pd_move_top_tb.sv
`timescale 1ns / 1ps

module differential_drive_pd_move_top_tb;
  import ddpm_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 12;
  localparam int PHASE_BEATS = 145;
  localparam longint I32_HI = 64'sh7FFF_FFFF;
  localparam longint I32_LO = -64'sh8000_0000;

  typedef struct packed {
    logic [15:0] left_drive;
    logic [15:0] right_drive;
    logic        move_done;
    logic [31:0] remaining_error;
  } drive_result_t;

  typedef struct {
    bit            is_cfg;
    reg_addr_t     addr;
    logic [31:0]   value;
    cmd_t          cmd;
    logic [31:0]   ld, rd, la, ra;
    bit            typed;
    drive_result_t want;
  } dir_row_t;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_CYCLIC, READY_BURSTY} ready_style_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;   // left_dist_delta, right_dist_delta, left_angle_delta, right_angle_delta
  logic [0:0]   s_tuser;   // cmd
  logic         m_tvalid;
  logic         m_tready;
  logic [71:0]  m_tdata;   // left_drive, right_drive, move_done, remaining_error, zero fill
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  // Register mirror and controller state of the predictor.
  move_mode_t         cfg_mode;
  logic signed [31:0] cfg_target;
  logic [30:0]        cfg_tol;
  logic [15:0]        cfg_mgp, cfg_mgd, cfg_sgp, cfg_sgd;
  bit                 pm_active;
  longint             pm_main, pm_steer;

  drive_result_t drive_q[$];
  dir_row_t      dir_tab[$];
  ready_style_t  rdy_mode = READY_ALWAYS;
  int            rdy_count = 0;
  int            stall_left = 0;
  int            idle_cycles = 0;
  int            errors = 0;
  int            beats_sent = 0;
  int            results_checked = 0;
  int            moves_finished = 0;
  int            reg_writes = 0;

  differential_drive_pd_move_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Q8.8 gain times Q15.16 error, scaled back with truncation toward zero.
  function automatic longint pd_q88(logic [15:0] gp, logic [15:0] gd, longint e, longint prev);
    return (longint'(gp) * e + longint'(gd) * (e - prev)) / 64'sd65536;
  endfunction

  function automatic drive_result_t predict_drive(cmd_t c, logic signed [31:0] ld,
                                                  logic signed [31:0] rd,
                                                  logic signed [31:0] la,
                                                  logic signed [31:0] ra);
    longint prev_m, prev_s, mag, mt, st, l, r, lim;
    drive_result_t res;
    lim = longint'(DRIVE_LIMIT);
    res.left_drive = '0;
    res.right_drive = '0;
    res.move_done = 1'b1;
    if (c == CMD_START) begin
      pm_main = cfg_target;
      pm_steer = 0;
      mag = pm_main < 0 ? -pm_main : pm_main;
      pm_active = mag > longint'(cfg_tol);
      res.move_done = !pm_active;
    end else if (pm_active) begin
      prev_m = pm_main;
      prev_s = pm_steer;
      if (cfg_mode == MODE_STRAIGHT) begin
        pm_main = clamp_range(pm_main - (longint'(ld) + longint'(rd)) / 2, I32_LO, I32_HI);
        pm_steer = clamp_range(longint'(rd) - longint'(ld), I32_LO, I32_HI);
      end else begin
        pm_main = clamp_range(pm_main - (longint'(la) + longint'(ra)) / 2, I32_LO, I32_HI);
        pm_steer = clamp_range(longint'(rd) + longint'(ld), I32_LO, I32_HI);
      end
      mag = pm_main < 0 ? -pm_main : pm_main;
      if (mag <= longint'(cfg_tol)) begin
        pm_active = 1'b0;
        moves_finished++;
      end else begin
        mt = pd_q88(cfg_mgp, cfg_mgd, pm_main, prev_m);
        st = pd_q88(cfg_sgp, cfg_sgd, pm_steer, prev_s);
        if (cfg_mode == MODE_STRAIGHT) begin
          mt = clamp_range(mt, -lim, lim);
          l = mt + st;
          r = mt - st;
        end else begin
          l = mt - st;
          r = -mt - st;
        end
        res.left_drive = 16'(clamp_range(l, -lim, lim));
        res.right_drive = 16'(clamp_range(r, -lim, lim));
        res.move_done = 1'b0;
      end
    end
    res.remaining_error = 32'(pm_main);
    return res;
  endfunction

  function automatic dir_row_t cfg_row(reg_addr_t a, logic [31:0] v);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.addr = a;
    row.value = v;
    row.cmd = CMD_TICK;
    row.ld = '0;
    row.rd = '0;
    row.la = '0;
    row.ra = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t beat_row(cmd_t c, logic [31:0] ld, logic [31:0] rd,
                                        logic [31:0] la, logic [31:0] ra);
    dir_row_t row;
    row = cfg_row(REG_MOVE_MODE, '0);
    row.is_cfg = 1'b0;
    row.cmd = c;
    row.ld = ld;
    row.rd = rd;
    row.la = la;
    row.ra = ra;
    return row;
  endfunction

  function automatic dir_row_t checked_row(cmd_t c, logic [31:0] ld, logic [31:0] rd,
                                           logic [31:0] la, logic [31:0] ra,
                                           logic [15:0] el, logic [15:0] er,
                                           logic ed, logic [31:0] ee);
    dir_row_t row;
    row = beat_row(c, ld, rd, la, ra);
    row.typed = 1'b1;
    row.want = '{el, er, ed, ee};
    return row;
  endfunction

  function automatic logic [31:0] rough_delta();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic longint jitter(longint step);
    longint spread;
    spread = (step < 0 ? -step : step) / 8 + 64;
    return longint'($urandom_range(0, 32'(2 * spread))) - spread;
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd65535;
      default: return $urandom_range(0, 1024);
    endcase
  endfunction

  task automatic settle();
    s_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_addr_t a, logic [31:0] v);
    bit rdy;
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {a, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel <= 1'b0;
    penable <= 1'b0;
    case (a)
      REG_MOVE_MODE:      cfg_mode = move_mode_t'(v[0]);
      REG_MOVE_TARGET:    cfg_target = v;
      REG_STOP_TOLERANCE: cfg_tol = v[30:0];
      REG_MAIN_GAIN_P:    cfg_mgp = v[15:0];
      REG_MAIN_GAIN_D:    cfg_mgd = v[15:0];
      REG_STEER_GAIN_P:   cfg_sgp = v[15:0];
      REG_STEER_GAIN_D:   cfg_sgd = v[15:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic send_beat(cmd_t c, logic [31:0] ld, logic [31:0] rd, logic [31:0] la,
                           logic [31:0] ra, bit typed, drive_result_t typed_res);
    bit ok;
    drive_result_t res;
    s_tvalid <= 1'b1;
    s_tuser <= c;
    s_tdata <= {ra, la, rd, ld};
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    res = predict_drive(c, ld, rd, la, ra);
    drive_q.push_back(typed ? typed_res : res);
    beats_sent++;
  endtask

  task automatic sender_gap(int n);
    s_tvalid <= 1'b0;
    s_tdata <= {$urandom, $urandom, $urandom, $urandom};
    s_tuser <= 1'($urandom_range(0, 1));
    repeat (n) @(posedge clk);
  endtask

  // Receiver stall patterns; the stimulus picks one per phase.
  always @(posedge clk) begin
    case (rdy_mode)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_COIN:   m_tready <= $urandom_range(0, 2) != 0;
      READY_CYCLIC: begin
        m_tready <= (rdy_count % 7) < 4;
        rdy_count++;
      end
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          m_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(1, 12);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  // Handshakes are sampled mid-cycle, where every signal is settled.
  always @(negedge clk) begin
    drive_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (drive_q.size() == 0) begin
        $error("result beat arrived with nothing pending");
        errors++;
      end else begin
        want = drive_q.pop_front();
        if (m_tdata[15:0] !== want.left_drive) begin
          $error("left_drive: expected %0d, got %0d",
                 $signed(want.left_drive), $signed(m_tdata[15:0]));
          errors++;
        end
        if (m_tdata[31:16] !== want.right_drive) begin
          $error("right_drive: expected %0d, got %0d",
                 $signed(want.right_drive), $signed(m_tdata[31:16]));
          errors++;
        end
        if (m_tdata[32] !== want.move_done) begin
          $error("move_done: expected %0d, got %0d", want.move_done, m_tdata[32]);
          errors++;
        end
        if (m_tdata[64:33] !== want.remaining_error) begin
          $error("remaining_error: expected %0d, got %0d",
                 $signed(want.remaining_error), $signed(m_tdata[64:33]));
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("No beat moved for %0d cycles, %0d results outstanding",
                 idle_cycles, drive_q.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int r, counted, burst;
    bit paused, gappy;
    cmd_t c;
    logic [31:0] ld, rd, la, ra;
    longint step;

    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    m_tready <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    cfg_mode = MODE_STRAIGHT;
    cfg_target = '0;
    cfg_tol = TOL_RESET;
    cfg_mgp = MAIN_GP_RESET;
    cfg_mgd = MAIN_GD_RESET;
    cfg_sgp = STEER_GP_RESET;
    cfg_sgd = STEER_GD_RESET;
    pm_active = 1'b0;
    pm_main = 0;
    pm_steer = 0;

    // Straight mode at reset values: idle tick, start inside tolerance, saturation.
    dir_tab.push_back(checked_row(CMD_TICK, 32'h1, 32'h2, 32'h3, 32'h4, 0, 0, 1, 0));
    dir_tab.push_back(checked_row(CMD_START, '0, '0, '0, '0, 0, 0, 1, 0));
    dir_tab.push_back(cfg_row(REG_MOVE_TARGET, 32'd6553600));
    dir_tab.push_back(checked_row(CMD_START, '0, '0, '0, '0, 0, 0, 0, 32'd6553600));
    dir_tab.push_back(checked_row(CMD_TICK, 32'h1_0000, 32'h1_0000, '0, '0,
                                  16'd25600, 16'd25600, 0, 32'd6488064));
    dir_tab.push_back(checked_row(CMD_TICK, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                                  32'h7FFF_FFFF, 16'd25600, 16'd25600, 0, 32'h7FFF_FFFF));
    dir_tab.push_back(checked_row(CMD_TICK, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0,
                                  -16'sd25600, 16'd25600, 0, 32'h7FFF_FFFF));
    dir_tab.push_back(checked_row(CMD_TICK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, 0, 0, 1, 0));
    dir_tab.push_back(checked_row(CMD_TICK, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                  32'hAAAA_AAAA, 0, 0, 1, 0));
    // Rotate mode from the most negative target.
    dir_tab.push_back(cfg_row(REG_MOVE_MODE, 32'(MODE_ROTATE)));
    dir_tab.push_back(cfg_row(REG_MOVE_TARGET, 32'h8000_0000));
    dir_tab.push_back(checked_row(CMD_START, '0, '0, '0, '0, 0, 0, 0, 32'h8000_0000));
    dir_tab.push_back(beat_row(CMD_TICK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1_0000, 32'h1_0000));
    dir_tab.push_back(checked_row(CMD_TICK, '0, '0, 32'h8000_0000, 32'h8000_0000, 0, 0, 1, 0));
    // Full-scale gains with zero tolerance, then a mode switch in the middle of a move.
    dir_tab.push_back(cfg_row(REG_MAIN_GAIN_P, 32'd65535));
    dir_tab.push_back(cfg_row(REG_MAIN_GAIN_D, 32'd65535));
    dir_tab.push_back(cfg_row(REG_STEER_GAIN_P, 32'd65535));
    dir_tab.push_back(cfg_row(REG_STEER_GAIN_D, 32'd65535));
    dir_tab.push_back(cfg_row(REG_STOP_TOLERANCE, 32'd0));
    dir_tab.push_back(cfg_row(REG_MOVE_TARGET, 32'h7FFF_FFFF));
    dir_tab.push_back(checked_row(CMD_START, '0, '0, '0, '0, 0, 0, 0, 32'h7FFF_FFFF));
    dir_tab.push_back(beat_row(CMD_TICK, 32'h0000_1234, 32'hFFF0_0000, 32'h2_0000, 32'h3_0000));
    dir_tab.push_back(beat_row(CMD_TICK, 32'h0004_0000, 32'h0001_8000, 32'hFFFF_0000,
                               32'hFFFF_0000));
    dir_tab.push_back(cfg_row(REG_MOVE_MODE, 32'(MODE_STRAIGHT)));
    dir_tab.push_back(beat_row(CMD_TICK, 32'h0010_0000, 32'h0008_0000, 32'hFF00_0000,
                               32'h0F00_0000));
    // Largest tolerance: the most negative target is the only one still outside it.
    dir_tab.push_back(cfg_row(REG_STOP_TOLERANCE, 32'h7FFF_FFFF));
    dir_tab.push_back(cfg_row(REG_MOVE_MODE, 32'(MODE_ROTATE)));
    dir_tab.push_back(checked_row(CMD_START, '0, '0, '0, '0, 0, 0, 1, 32'h7FFF_FFFF));
    dir_tab.push_back(cfg_row(REG_MOVE_TARGET, 32'h8000_0000));
    dir_tab.push_back(checked_row(CMD_START, '0, '0, '0, '0, 0, 0, 0, 32'h8000_0000));
    dir_tab.push_back(checked_row(CMD_TICK, '0, '0, '0, '0,
                                  -16'sd25600, 16'd25600, 0, 32'h8000_0000));
    // Error exactly at the tolerance counts as done, one step beyond does not.
    dir_tab.push_back(cfg_row(REG_STOP_TOLERANCE, 32'd3277));
    dir_tab.push_back(cfg_row(REG_MOVE_TARGET, 32'hFFFF_F333));
    dir_tab.push_back(checked_row(CMD_START, '0, '0, '0, '0, 0, 0, 1, 32'hFFFF_F333));
    dir_tab.push_back(cfg_row(REG_MOVE_TARGET, 32'hFFFF_F332));
    dir_tab.push_back(checked_row(CMD_START, '0, '0, '0, '0, 0, 0, 0, 32'hFFFF_F332));
    dir_tab.push_back(checked_row(CMD_TICK, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  0, 0, 1, 32'hFFFF_F333));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    rdy_mode = READY_COIN;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        write_reg(dir_tab[i].addr, dir_tab[i].value);
      end else begin
        send_beat(dir_tab[i].cmd, dir_tab[i].ld, dir_tab[i].rd, dir_tab[i].la,
                  dir_tab[i].ra, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(REG_MOVE_MODE, $urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: write_reg(REG_MOVE_TARGET, $urandom);
        1: write_reg(REG_MOVE_TARGET, $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
        default: write_reg(REG_MOVE_TARGET, 32'($urandom_range(0, 1) ? 1 : -1) *
                                            ($urandom_range(1, 500) << 16));
      endcase
      case ($urandom_range(0, 11))
        0: write_reg(REG_STOP_TOLERANCE, 32'd0);
        1: write_reg(REG_STOP_TOLERANCE, 32'h7FFF_FFFF);
        2: write_reg(REG_STOP_TOLERANCE, $urandom);
        default: write_reg(REG_STOP_TOLERANCE, $urandom_range(0, 65536));
      endcase
      write_reg(REG_MAIN_GAIN_P, pick_gain());
      write_reg(REG_MAIN_GAIN_D, pick_gain());
      write_reg(REG_STEER_GAIN_P, pick_gain());
      write_reg(REG_STEER_GAIN_D, pick_gain());
      rdy_mode = ready_style_t'(ph % 4);
      gappy = (ph % 3) != 0;
      paused = 1'b0;
      counted = 0;
      burst = $urandom_range(1, 20);
      while (counted < PHASE_BEATS) begin
        r = $urandom_range(0, 99);
        if (r < 8 || (r >= 14 && !pm_active)) begin
          c = CMD_START;
          ld = $urandom;
          rd = $urandom;
          la = $urandom;
          ra = $urandom;
        end else if (r < 14) begin
          c = CMD_TICK;
          ld = rough_delta();
          rd = rough_delta();
          la = rough_delta();
          ra = rough_delta();
        end else begin
          // Deltas that close a share of the remaining error, so moves run to their end.
          c = CMD_TICK;
          step = pm_main / longint'($urandom_range(2, 12));
          ld = 32'(step + jitter(step));
          rd = 32'(step + jitter(step));
          la = 32'(step + jitter(step));
          ra = 32'(step + jitter(step));
        end
        if (c == CMD_START || pm_active) counted++;
        send_beat(c, ld, rd, la, ra, 1'b0, '0);
        if (ph % 4 == 1 && !paused && counted >= PHASE_BEATS / 2) begin
          settle();
          paused = 1'b1;
        end
        if (gappy) begin
          burst--;
          if (burst == 0) begin
            sender_gap($urandom_range(1, 8));
            burst = $urandom_range(1, 20);
          end
        end
      end
    end

    s_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Drove %0d beats over %0d register writes in both modes, with saturating",
             beats_sent, reg_writes);
    $display("deltas, gain and tolerance extremes; %0d results checked, %0d moves finished.",
             results_checked, moves_finished);
    if (errors == 0 && drive_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
